FILE: hw/rtl/keyed_integer_field_extractor_top_assert.svh
// ============================================================================
// keyed_integer_field_extractor_top_assert.svh
// Assertion macros shared by the extractor RTL; they expand to nothing in
// synthesis. Each macro expects clk and arst_n in the enclosing module.
// ============================================================================
`ifndef KEYED_INTEGER_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define KEYED_INTEGER_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// plain invariant, checked at every edge out of reset
`define KIFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// same-cycle implication
`define KIFE_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
// next-cycle implication
`define KIFE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define KIFE_ASSERT(lbl, prop, msg)
`define KIFE_ASSERT_IMPL(lbl, pre, post, msg)
`define KIFE_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: hw/rtl/kife_pkg.sv
// ============================================================================
// kife_pkg
// Types, character codes and key tables for the keyed integer extractor.
// ============================================================================
`default_nettype none

package kife_pkg;

	// value arithmetic width (saturation limits) and result field width
	localparam int VALUE_BITS  = 32;
	localparam int FIELD_BITS  = 32;
	localparam int PROD_W      = VALUE_BITS + 4;

	// key bookkeeping
	localparam int NUM_KEYS    = 4;
	localparam int KEY_MAX_LEN = 5;
	localparam int KI_W        = 3;   // holds 0..NUM_KEYS
	localparam int MP_W        = 3;   // holds 0..KEY_MAX_LEN-1
	localparam int KSEL_W      = 2;   // selects one of NUM_KEYS

	localparam logic [KI_W-1:0] KEY_IDX_MAX = KI_W'(NUM_KEYS);

	// saturation limits
	localparam logic [VALUE_BITS-1:0] LIMIT_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] LIMIT_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_LC_C  = 8'h63;
	localparam logic [7:0] CH_LC_M  = 8'h6D;

	// quoted keys, searched in this order; unused tail entries are never read
	localparam logic [7:0] KEY_TEXT [NUM_KEYS][KEY_MAX_LEN] = '{
		'{CH_QUOTE, CH_D, CH_QUOTE, CH_NUL, CH_NUL},
		'{CH_QUOTE, CH_P, CH_QUOTE, CH_NUL, CH_NUL},
		'{CH_QUOTE, CH_X, CH_LC_C, CH_LC_M, CH_QUOTE},
		'{CH_QUOTE, CH_Y, CH_LC_C, CH_LC_M, CH_QUOTE}
	};
	localparam logic [MP_W-1:0] KEY_LEN [NUM_KEYS] = '{3'd3, 3'd3, 3'd5, 3'd5};

	// value conversion phase
	typedef enum logic [1:0] {
		STG_SEARCH,
		STG_SKIP,
		STG_LEAD,
		STG_DIGIT
	} num_stage_t;

	// one result item
	typedef struct packed {
		logic signed [FIELD_BITS-1:0] distance;
		logic signed [FIELD_BITS-1:0] phase_value;
		logic signed [FIELD_BITS-1:0] x_position;
		logic signed [FIELD_BITS-1:0] y_position;
		logic [NUM_KEYS-1:0]          keys_found;
		logic                         value_overflow;
	} result_t;

	// mask of the first n keys
	function automatic logic [NUM_KEYS-1:0] key_mask(input logic [KI_W-1:0] n);
		logic [NUM_KEYS:0] m;
		m = ({{NUM_KEYS{1'b0}}, 1'b1} << n) - 1'b1;
		return m[NUM_KEYS-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/kife_in_stage.sv
// ============================================================================
// kife_in_stage
// Input register: holds one text byte until the parser consumes it.
// ============================================================================
`default_nettype none

module kife_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] text_byte,
	output logic       in_ready,
	input  logic       step,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import kife_pkg::*;

	logic accept;

	// free when empty or when the held item moves on this cycle
	assign in_ready = !valid_s1 || step;
	assign accept   = in_valid && in_ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_byte;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/kife_parser.sv
// ============================================================================
// kife_parser
// Per-line state: key matcher, atoi-style value converter and field store.
// Consumes one byte per step and builds the result at the newline.
// ============================================================================
`default_nettype none
`include "keyed_integer_field_extractor_top_assert.svh"

module kife_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_s1,
	output logic              res_emit,
	output kife_pkg::result_t res
);
	import kife_pkg::*;

	// line state
	logic [KI_W-1:0]       ki_q, ki_n;
	logic [MP_W-1:0]       mp_q, mp_n;
	num_stage_t            stg_q, stg_n;
	logic                  neg_q, neg_n;
	logic [VALUE_BITS-1:0] acc_q, acc_n;
	logic [VALUE_BITS-1:0] fv_q [NUM_KEYS];
	logic [NUM_KEYS-1:0]   found_q, found_n;
	logic                  ovf_q, ovf_n;
	logic                  ne_q, ne_n;
	logic                  stop_q, stop_n;

	// byte classes
	logic is_nl, is_nul, is_digit, is_ws, is_sign, is_quote;

	// arithmetic
	logic [PROD_W-1:0]     acc_x10;
	logic [VALUE_BITS-1:0] limit;
	logic                  sat;
	logic [VALUE_BITS-1:0] acc_add;
	logic [VALUE_BITS-1:0] fin_val;
	logic [KSEL_W-1:0]     fin_idx;
	logic                  fin;
	logic                  nl_fin;

	// matcher
	logic [KSEL_W-1:0]     ksel;
	logic                  hit;
	logic                  last;

	logic [VALUE_BITS-1:0] fv_out [NUM_KEYS];

	// classify the byte
	always_comb begin
		is_nl    = byte_s1 == CH_NL;
		is_nul   = byte_s1 == CH_NUL;
		is_digit = (byte_s1 >= CH_0) && (byte_s1 <= CH_9);
		is_ws    = (byte_s1 == CH_TAB) || (byte_s1 == CH_VT) || (byte_s1 == CH_FF) ||
		           (byte_s1 == CH_CR) || (byte_s1 == CH_SP);
		is_sign  = (byte_s1 == CH_PLUS) || (byte_s1 == CH_MINUS);
		is_quote = byte_s1 == CH_QUOTE;
	end

	// acc*10 + digit with saturation; limit is one larger for negatives
	assign acc_x10 = PROD_W'({acc_q, 3'b000}) + PROD_W'({acc_q, 1'b0}) + PROD_W'(byte_s1[3:0]);
	assign limit   = neg_q ? LIMIT_NEG : LIMIT_POS;
	assign sat     = acc_x10 > PROD_W'(limit);
	assign acc_add = sat ? limit : acc_x10[VALUE_BITS-1:0];

	// finished value goes to the slot of the last key found.
	// Every key ends in a quote, which already closes a running value, so a
	// key completion never has to finish a value itself: the stored value is
	// always built from the registered accumulator.
	assign fin_val = neg_q ? (~acc_q + 1'b1) : acc_q;
	assign fin_idx = KSEL_W'(ki_q - 1'b1);
	assign nl_fin  = stg_q != STG_SEARCH;

	// key matcher lookup
	assign ksel = ki_q[KSEL_W-1:0];
	assign hit  = byte_s1 == KEY_TEXT[ksel][mp_q];
	assign last = (mp_q + 1'b1) == KEY_LEN[ksel];

	// next line state
	always_comb begin
		ki_n    = ki_q;
		mp_n    = mp_q;
		stg_n   = stg_q;
		neg_n   = neg_q;
		acc_n   = acc_q;
		found_n = found_q;
		ovf_n   = ovf_q;
		ne_n    = ne_q;
		stop_n  = stop_q;
		fin     = 1'b0;
		if (step) begin
			if (is_nl) begin
				ki_n    = '0;
				mp_n    = '0;
				stg_n   = STG_SEARCH;
				neg_n   = 1'b0;
				acc_n   = '0;
				found_n = '0;
				ovf_n   = 1'b0;
				ne_n    = 1'b0;
				stop_n  = 1'b0;
			end else begin
				ne_n = 1'b1;
				if (!stop_q) begin
					if (is_nul) begin
						// string end: close the value, ignore the rest of the line
						fin    = stg_q != STG_SEARCH;
						stg_n  = STG_SEARCH;
						stop_n = 1'b1;
					end else if (stg_q == STG_SKIP) begin
						stg_n = STG_LEAD;
					end else begin
						// value conversion
						case (stg_q)
							STG_LEAD: begin
								if (is_sign) begin
									neg_n = byte_s1 == CH_MINUS;
									stg_n = STG_DIGIT;
								end else if (is_digit) begin
									acc_n = acc_add;
									ovf_n = ovf_q || sat;
									stg_n = STG_DIGIT;
								end else if (!is_ws) begin
									fin   = 1'b1;
									stg_n = STG_SEARCH;
								end
							end
							STG_DIGIT: begin
								if (is_digit) begin
									acc_n = acc_add;
									ovf_n = ovf_q || sat;
								end else begin
									fin   = 1'b1;
									stg_n = STG_SEARCH;
								end
							end
							default: begin
							end
						endcase
						// key search overlaps the value
						if (ki_q != KEY_IDX_MAX) begin
							if (hit && last) begin
								found_n = found_q | (NUM_KEYS'(1) << ksel);
								ki_n    = ki_q + 1'b1;
								mp_n    = '0;
								stg_n   = STG_SKIP;
								neg_n   = 1'b0;
								acc_n   = '0;
							end else if (hit) begin
								mp_n = mp_q + 1'b1;
							end else begin
								mp_n = {{(MP_W-1){1'b0}}, is_quote};
							end
						end
					end
				end
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ki_q    <= '0;
			mp_q    <= '0;
			stg_q   <= STG_SEARCH;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			found_q <= '0;
			ovf_q   <= 1'b0;
			ne_q    <= 1'b0;
			stop_q  <= 1'b0;
		end else begin
			ki_q    <= ki_n;
			mp_q    <= mp_n;
			stg_q   <= stg_n;
			neg_q   <= neg_n;
			acc_q   <= acc_n;
			found_q <= found_n;
			ovf_q   <= ovf_n;
			ne_q    <= ne_n;
			stop_q  <= stop_n;
		end
	end

	// field store: cleared per line, missing keys read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				fv_q[i] <= '0;
			end
		end else if (step && is_nl) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				fv_q[i] <= '0;
			end
		end else if (fin) begin
			fv_q[fin_idx] <= fin_val;
		end
	end

	// result at the newline, with any running value closed
	always_comb begin
		res_emit = is_nl && ne_q;
		for (int i = 0; i < NUM_KEYS; i++) begin
			fv_out[i] = (nl_fin && (fin_idx == KSEL_W'(i))) ? fin_val : fv_q[i];
		end
		res.distance       = FIELD_BITS'(signed'(fv_out[0]));
		res.phase_value    = FIELD_BITS'(signed'(fv_out[1]));
		res.x_position     = FIELD_BITS'(signed'(fv_out[2]));
		res.y_position     = FIELD_BITS'(signed'(fv_out[3]));
		res.keys_found     = found_q;
		res.value_overflow = ovf_q;
	end

	`KIFE_ASSERT(a_key_idx_range, ki_q <= KEY_IDX_MAX, "key index past last key")
	`KIFE_ASSERT(a_mask_in_order, found_q == key_mask(ki_q), "found mask not in key order")
	`KIFE_ASSERT_IMPL(a_value_has_key, stg_q != STG_SEARCH, ki_q != '0, "value without key")
	`KIFE_ASSERT_NEXT(a_nl_clears, step && is_nl, !ne_q && (ki_q == '0) && !ovf_q, "line not cleared")

endmodule

`default_nettype wire

FILE: hw/rtl/kife_out_stage.sv
// ============================================================================
// kife_out_stage
// Result register: holds one result item until the consumer takes it.
// ============================================================================
`default_nettype none
`include "keyed_integer_field_extractor_top_assert.svh"

module kife_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  kife_pkg::result_t res_in,
	input  logic              out_ready,
	output logic              out_valid,
	output kife_pkg::result_t res_q
);
	import kife_pkg::*;

	logic out_valid_q;

	assign out_valid = out_valid_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	`KIFE_ASSERT(a_no_overrun, !(load && out_valid_q && !out_ready), "result overwritten")

endmodule

`default_nettype wire

FILE: hw/rtl/keyed_integer_field_extractor_top.sv
// ============================================================================
// keyed_integer_field_extractor_top: extracts D, P, Xcm, Ycm integers per line
// Throughput: one text byte per cycle, except while a newline's result has nowhere to go.
// A newline passes from the input register through the parser into the result register, which raises out_valid.
// A newline waits in the input register while an earlier result is unread.
// Reset (arst_n low, async): input and result registers empty, line state clear.
// ============================================================================
`default_nettype none

module keyed_integer_field_extractor_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           text_byte,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [kife_pkg::FIELD_BITS-1:0] distance,
	output logic signed [kife_pkg::FIELD_BITS-1:0] phase_value,
	output logic signed [kife_pkg::FIELD_BITS-1:0] x_position,
	output logic signed [kife_pkg::FIELD_BITS-1:0] y_position,
	output logic [kife_pkg::NUM_KEYS-1:0]        keys_found,
	output logic                                 value_overflow
);
	import kife_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step;
	logic       res_emit;
	result_t    res_d;
	result_t    res_q;

	// a newline waits only when its result has nowhere to go
	assign step = valid_s1 && !(res_emit && out_valid && !out_ready);

	kife_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.text_byte (text_byte),
		.in_ready  (in_ready),
		.step      (step),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	kife_parser u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.byte_s1  (byte_s1),
		.res_emit (res_emit),
		.res      (res_d)
	);

	kife_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_emit),
		.res_in    (res_d),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	// result fields to ports
	assign distance       = res_q.distance;
	assign phase_value    = res_q.phase_value;
	assign x_position     = res_q.x_position;
	assign y_position     = res_q.y_position;
	assign keys_found     = res_q.keys_found;
	assign value_overflow = res_q.value_overflow;

endmodule

`default_nettype wire

FILE: tb/tb_keyed_integer_field_extractor_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_keyed_integer_field_extractor_top
// Feeds text lines byte by byte into the key/integer extractor and checks each
// line result against an in-bench model of the key search and atoi conversion.
// Stimulus is a short directed set of corner lines, then random record lines,
// broken records and noise, with random input gaps and output stalls.
// ============================================================================

module tb_keyed_integer_field_extractor_top;
	import kife_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int RANDOM_ITEMS  = 1750;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 400;
	localparam int MAX_PRINTS    = 50;

	localparam logic [7:0] CH_COLON = 8'h3A;

	typedef struct {
		logic [7:0] ch;
		bit         drain_first;
	} text_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid;
	logic in_ready;
	logic [7:0] text_byte;
	logic out_valid;
	logic out_ready;
	logic signed [FIELD_BITS-1:0] distance;
	logic signed [FIELD_BITS-1:0] phase_value;
	logic signed [FIELD_BITS-1:0] x_position;
	logic signed [FIELD_BITS-1:0] y_position;
	logic [NUM_KEYS-1:0] keys_found;
	logic value_overflow;

	// bench bookkeeping
	text_item_t pending_text [$];
	result_t expected_lines [$];
	bit drain_next = 1'b0;
	int unsigned error_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned lines_checked = 0;
	int unsigned full_lines = 0;
	int unsigned saturated_lines = 0;
	int unsigned input_stalls = 0;
	int unsigned cycle_count = 0;
	logic long_hold;

	// line parser state
	int unsigned key_pos;
	int unsigned match_len;
	num_stage_t conv_stage;
	bit conv_negative;
	logic [63:0] magnitude;
	logic [63:0] field_val [NUM_KEYS];
	logic [NUM_KEYS-1:0] found_keys;
	bit saw_overflow;
	bit line_has_text;
	bit line_halted;

	keyed_integer_field_extractor_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.text_byte      (text_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.distance       (distance),
		.phase_value    (phase_value),
		.x_position     (x_position),
		.y_position     (y_position),
		.keys_found     (keys_found),
		.value_overflow (value_overflow)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// line parser: key search, skip byte, atoi conversion with saturation
	// ------------------------------------------------------------------------
	task automatic clear_line();
		key_pos = 0;
		match_len = 0;
		conv_stage = STG_SEARCH;
		conv_negative = 1'b0;
		magnitude = '0;
		for (int i = 0; i < NUM_KEYS; i++)
			field_val[i] = '0;
		found_keys = '0;
		saw_overflow = 1'b0;
		line_has_text = 1'b0;
		line_halted = 1'b0;
	endtask

	// store the value in progress under the last key found
	task automatic close_value();
		if (conv_stage != STG_SEARCH && key_pos >= 1 && key_pos <= NUM_KEYS)
			field_val[key_pos - 1] = conv_negative ? 64'd0 - magnitude : magnitude;
		conv_stage = STG_SEARCH;
	endtask

	task automatic add_digit(input logic [7:0] c);
		logic [63:0] digit;
		logic [63:0] limit;
		digit = 64'(c - CH_0);
		limit = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
		if (conv_negative)
			limit = limit + 64'd1;
		if (magnitude > (limit - digit) / 64'd10) begin
			magnitude = limit;
			saw_overflow = 1'b1;
		end else begin
			magnitude = magnitude * 64'd10 + digit;
		end
	endtask

	task automatic parse_byte(input logic [7:0] c);
		result_t line_result;
		bit is_digit;
		bit is_space;
		is_digit = (c >= CH_0) && (c <= CH_9);
		is_space = (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR) ||
			(c == CH_SP);
		if (c == CH_NL) begin
			// an empty line gives nothing
			if (line_has_text) begin
				close_value();
				line_result.distance = field_val[0][FIELD_BITS-1:0];
				line_result.phase_value = field_val[1][FIELD_BITS-1:0];
				line_result.x_position = field_val[2][FIELD_BITS-1:0];
				line_result.y_position = field_val[3][FIELD_BITS-1:0];
				line_result.keys_found = found_keys;
				line_result.value_overflow = saw_overflow;
				expected_lines.push_back(line_result);
			end
			clear_line();
		end else begin
			line_has_text = 1'b1;
			if (!line_halted) begin
				if (c == CH_NUL) begin
					// zero byte ends the text; rest of the line is ignored
					close_value();
					line_halted = 1'b1;
				end else if (conv_stage == STG_SKIP) begin
					conv_stage = STG_LEAD;
				end else begin
					case (conv_stage)
						STG_LEAD: begin
							if (is_space) begin
							end else if (c == CH_PLUS || c == CH_MINUS) begin
								conv_negative = (c == CH_MINUS);
								conv_stage = STG_DIGIT;
							end else if (is_digit) begin
								add_digit(c);
								conv_stage = STG_DIGIT;
							end else begin
								close_value();
							end
						end
						STG_DIGIT: begin
							if (is_digit)
								add_digit(c);
							else
								close_value();
						end
						default: ;
					endcase
					// key search runs over the value text too
					if (key_pos < NUM_KEYS) begin
						if (match_len < KEY_LEN[key_pos] &&
								c == KEY_TEXT[key_pos][match_len]) begin
							match_len++;
							if (match_len == KEY_LEN[key_pos]) begin
								close_value();
								found_keys[key_pos] = 1'b1;
								key_pos++;
								match_len = 0;
								conv_stage = STG_SKIP;
								conv_negative = 1'b0;
								magnitude = '0;
							end
						end else begin
							match_len = (c == CH_QUOTE) ? 1 : 0;
						end
					end
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// stimulus builders
	// ------------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] c);
		text_item_t item;
		item.ch = c;
		item.drain_first = drain_next;
		drain_next = 1'b0;
		pending_text.push_back(item);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] any_text_byte();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == CH_NL)
			c = 8'($urandom_range(11, 255));
		return c;
	endfunction

	// optional whitespace, optional sign, digits of various lengths or none
	task automatic push_value();
		logic [7:0] blanks [5];
		string edges [5];
		blanks = '{CH_TAB, CH_VT, CH_FF, CH_CR, CH_SP};
		edges = '{"2147483647", "2147483648", "2147483649", "21474836470", "4294967295"};
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) push_byte(blanks[$urandom_range(0, 4)]);
		case ($urandom_range(0, 5))
			0: push_byte(CH_MINUS);
			1: push_byte(CH_PLUS);
			default: ;
		endcase
		case ($urandom_range(0, 9))
			0: push_text("0");
			1, 2, 3, 4: push_text($sformatf("%0d", $urandom_range(0, 9999)));
			5: push_text($sformatf("%0d", $urandom));
			6: push_text(edges[$urandom_range(0, 4)]);
			7: repeat ($urandom_range(11, 25)) push_byte(8'(CH_0 + $urandom_range(0, 9)));
			8: ;
			default: push_text($sformatf("000%0d", $urandom_range(0, 99)));
		endcase
	endtask

	// record line: keys in order, sometimes dropped, cut short or garbled
	task automatic push_record_line(input bit garble);
		string key_str [NUM_KEYS];
		int unsigned drop;
		int unsigned stop_at;
		key_str = '{"\"D\"", "\"P\"", "\"Xcm\"", "\"Ycm\""};
		drop = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : NUM_KEYS;
		stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : NUM_KEYS;
		if ($urandom_range(0, 1))
			push_text("{");
		for (int k = 0; k < stop_at; k++) begin
			if (k != drop) begin
				push_text(key_str[k]);
				if ($urandom_range(0, 15) == 0) begin
					push_byte(CH_NL);
					return;
				end
				push_byte(($urandom_range(0, 7) == 0) ? any_text_byte() : CH_COLON);
				push_value();
				if ($urandom_range(0, 19) == 0)
					push_byte(CH_NUL);
				if (garble)
					repeat ($urandom_range(0, 3)) push_byte(any_text_byte());
				push_text(($urandom_range(0, 3) == 0) ? " " : ",");
			end
		end
		push_text("}\n");
	endtask

	// noise with quotes and key fragments; rarely very long
	task automatic push_noise_line();
		string frags [6];
		int unsigned n;
		frags = '{"\"D", "\"\"P\"", "Xcm\"", "\"Ycm", "\"X\"cm\"", "\"D\"-"};
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(150, 300) : $urandom_range(1, 24);
		repeat (n) begin
			case ($urandom_range(0, 5))
				0: push_byte(CH_QUOTE);
				1: push_text(frags[$urandom_range(0, 5)]);
				default: push_byte(any_text_byte());
			endcase
		end
		push_byte(CH_NL);
	endtask

	// ------------------------------------------------------------------------
	// driver: bursts with random gaps, optional wait for drain
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : p_drive
		int unsigned burst_left;
		int unsigned gap_left;
		bit accepted;
		bit next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			text_byte <= 8'h00;
			burst_left = 0;
			gap_left = 0;
		end else begin
			accepted = in_valid && in_ready;
			if (in_valid && !in_ready)
				input_stalls++;
			if (accepted) begin
				parse_byte(text_byte);
				void'(pending_text.pop_front());
				bytes_sent++;
			end
			next_valid = 1'b0;
			if (in_valid && !accepted) begin
				next_valid = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pending_text.size() > 0 &&
					!(pending_text[0].drain_first && expected_lines.size() > 0)) begin
				next_valid = 1'b1;
				text_byte <= pending_text[0].ch;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
			in_valid <= next_valid;
		end
	end

	// ------------------------------------------------------------------------
	// long output hold: lets the block back up and stall its input
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : p_hold
		int unsigned hold_left;
		int unsigned holds_done;
		int unsigned next_hold_at;
		if (!arst_n) begin
			long_hold <= 1'b0;
			hold_left = 0;
			holds_done = 0;
			next_hold_at = 500;
		end else if (hold_left > 0) begin
			hold_left--;
			long_hold <= (hold_left != 0);
		end else if (holds_done < 2 && bytes_sent >= next_hold_at) begin
			hold_left = HOLD_CYCLES;
			long_hold <= 1'b1;
			holds_done++;
			next_hold_at = next_hold_at + 700;
		end
	end

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("line %0d %s got %0d want %0d", lines_checked, name,
				$signed(got), $signed(want)));
	endtask

	always @(posedge clk or negedge arst_n) begin : p_check
		result_t want;
		int unsigned window_left;
		logic [15:0] ready_mask;
		if (!arst_n) begin
			out_ready <= 1'b0;
			window_left = 0;
			ready_mask = '1;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_lines.size() == 0) begin
					report_mismatch("result arrived with no line pending");
				end else begin
					want = expected_lines.pop_front();
					check_field("distance", distance, want.distance);
					check_field("phase_value", phase_value, want.phase_value);
					check_field("x_position", x_position, want.x_position);
					check_field("y_position", y_position, want.y_position);
					check_field("keys_found", 32'(keys_found), 32'(want.keys_found));
					check_field("value_overflow", 32'(value_overflow),
						32'(want.value_overflow));
					if (want.keys_found == '1)
						full_lines++;
					if (want.value_overflow)
						saturated_lines++;
				end
				lines_checked++;
			end
			// stall pattern changes every window; some windows never stall
			if (window_left == 0) begin
				window_left = $urandom_range(50, 300);
				case ($urandom_range(0, 3))
					0: ready_mask = '1;
					1: ready_mask = 16'($urandom);
					2: ready_mask = 16'($urandom | $urandom);
					default: ready_mask = 16'($urandom & $urandom);
				endcase
			end
			window_left--;
			ready_mask = {ready_mask[0], ready_mask[15:1]};
			out_ready <= ready_mask[0] && !long_hold;
		end
	end

	// ------------------------------------------------------------------------
	// run limit
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run stopped at cycle limit, %0d lines still pending",
				expected_lines.size());
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int unsigned pick;
		clear_line();

		// directed corners
		push_byte(CH_NL);                   // empty line
		push_text("\"D\"\n");               // key right before newline, later keys missing
		push_text("\"D\"");
		push_byte(CH_NUL);                  // zero byte in the skip position
		push_text("5\n");
		push_text("\"D\":-9999999999\n");   // negative saturation

		// random lines; the first waits for the directed results to drain
		drain_next = 1'b1;
		while (pending_text.size() < RANDOM_ITEMS + 27) begin
			if ($urandom_range(0, 40) == 0)
				drain_next = 1'b1;
			pick = $urandom_range(0, 19);
			if (pick < 13)
				push_record_line(1'b0);
			else if (pick < 16)
				push_record_line(1'b1);
			else if (pick < 19)
				push_noise_line();
			else
				push_byte(CH_NL);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_text.size() != 0 || expected_lines.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d text bytes, checked %0d line results", bytes_sent, lines_checked);
		$display("%0d lines with all keys, %0d saturated, %0d input stall cycles",
			full_lines, saturated_lines, input_stalls);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", error_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
